>>> rtl/core/rdcg_pkg.sv
package rdcg_pkg;

  localparam int DEF_MAX_ELEMENTS = 32;
  localparam int CFG_W = 6;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_IDX_W = 5;
  localparam int PHASE_W = 3;

  localparam logic [CFG_W-1:0] TOTAL_RESET = 6'd4;
  localparam logic [CFG_W-1:0] CHOSEN_RESET = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL  = 1'b0,
    REG_CHOSEN = 1'b1
  } cfg_reg_t;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  localparam logic [PHASE_W-1:0] PH_ENTER = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PAIR_A = 3'd1;
  localparam logic [PHASE_W-1:0] PH_MID = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAIR_B = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TAIL = 3'd4;

  typedef struct packed {
    logic accept;
    logic commit;
    logic load_top;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic yield;
    logic pop_read;
  } sts_t;

endpackage

>>> rtl/core/rdcg_ram.sv
module rdcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/rdcg_ctrl.sv
module rdcg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  rdcg_pkg::sts_t  sts,
  output rdcg_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.empty) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.yield) begin
          if (slot_free) begin
            cmd.commit = 1'b1;
            cmd.out_load = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.commit = 1'b1;
          if (sts.pop_read) begin
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load_top = 1'b1;
        state_next = S_STEP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/rdcg_dpath.sv
module rdcg_dpath #(
  parameter int MAX_ELEMENTS = rdcg_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [rdcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdcg_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               restart,
  input  rdcg_pkg::cmd_t                     cmd,
  output rdcg_pkg::sts_t                     sts,
  output logic [rdcg_pkg::OUT_IDX_W-1:0]     first_index,
  output logic [rdcg_pkg::OUT_IDX_W-1:0]     second_index,
  output logic                               pair_valid,
  output logic                               finished
);

  localparam int SW = $clog2(MAX_ELEMENTS + 1);
  localparam int FW = (SW > rdcg_pkg::CFG_W) ? SW : rdcg_pkg::CFG_W;
  localparam int LW = SW;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int PW = rdcg_pkg::PHASE_W;
  localparam int RW = 3 * FW + 1 + PW;

  typedef struct packed {
    logic [FW-1:0] size;
    logic [FW-1:0] choose;
    logic          dir;
    logic [PW-1:0] phase;
    logic [FW-1:0] idx;
  } frame_t;

  logic [rdcg_pkg::CFG_W-1:0] total_elements;
  logic [rdcg_pkg::CFG_W-1:0] chosen_size;

  frame_t        top;
  logic [LW-1:0] level;

  // step decode
  logic          yld;
  logic          do_pop;
  logic          do_child;
  logic          replace;
  logic [FW-1:0] pa;
  logic [FW-1:0] pb;
  logic [FW-1:0] c_n;
  logic [FW-1:0] c_k;
  logic          c_dir;
  logic [PW-1:0] phase_next;
  logic [FW-1:0] idx_next;
  logic          child_ok;
  logic          room;
  logic          pop_eff;
  logic          push_eff;
  frame_t        child;
  frame_t        parent;

  logic [LW-1:0] lvl_m1;
  logic [LW-1:0] lvl_m2;
  logic [RW-1:0] ram_rdata;

  // restart decode
  logic [FW-1:0] tot_ext;
  logic [FW-1:0] max_c;
  logic [FW-1:0] r_n;
  logic [FW-1:0] r_k;
  logic          r_ok;
  frame_t        r_frame;

  logic [FW:0]   idx_inc;

  assign idx_inc = {1'b0, top.idx} + (FW + 1)'(1);

  always_comb begin
    yld = 1'b0;
    do_pop = 1'b0;
    do_child = 1'b0;
    replace = 1'b0;
    pa = '0;
    pb = '0;
    c_n = '0;
    c_k = '0;
    c_dir = rdcg_pkg::DIR_FWD;
    phase_next = top.phase;
    idx_next = top.idx;
    if (top.choose == FW'(1)) begin
      if (top.dir == rdcg_pkg::DIR_FWD) begin
        if (idx_inc < {1'b0, top.size}) begin
          yld = 1'b1;
          pa = top.idx;
          pb = idx_inc[FW-1:0];
          idx_next = idx_inc[FW-1:0];
        end else begin
          do_pop = 1'b1;
        end
      end else if (top.idx != '0) begin
        yld = 1'b1;
        pa = top.idx;
        pb = top.idx - FW'(1);
        idx_next = top.idx - FW'(1);
      end else begin
        do_pop = 1'b1;
      end
    end else begin
      unique case (top.phase)
        rdcg_pkg::PH_ENTER: begin
          phase_next = rdcg_pkg::PH_PAIR_A;
          do_child = 1'b1;
          if (top.dir == rdcg_pkg::DIR_FWD) begin
            c_n = top.size - FW'(1);
            c_k = top.choose;
            c_dir = rdcg_pkg::DIR_FWD;
          end else begin
            c_n = top.size - FW'(2);
            c_k = top.choose - FW'(2);
            c_dir = rdcg_pkg::DIR_REV;
          end
        end
        rdcg_pkg::PH_PAIR_A: begin
          phase_next = rdcg_pkg::PH_MID;
          yld = 1'b1;
          pa = top.size - FW'(2);
          pb = (top.dir == rdcg_pkg::DIR_FWD) ? top.size - FW'(1) : top.choose - FW'(2);
        end
        rdcg_pkg::PH_MID: begin
          phase_next = rdcg_pkg::PH_PAIR_B;
          do_child = 1'b1;
          c_n = top.size - FW'(2);
          c_k = top.choose - FW'(1);
          c_dir = ~top.dir;
        end
        rdcg_pkg::PH_PAIR_B: begin
          phase_next = rdcg_pkg::PH_TAIL;
          yld = 1'b1;
          pa = (top.dir == rdcg_pkg::DIR_FWD) ? top.choose - FW'(2) : top.size - FW'(1);
          pb = top.size - FW'(2);
        end
        default: begin
          replace = 1'b1;
          if (top.dir == rdcg_pkg::DIR_FWD) begin
            c_n = top.size - FW'(2);
            c_k = top.choose - FW'(2);
            c_dir = rdcg_pkg::DIR_FWD;
          end else begin
            c_n = top.size - FW'(1);
            c_k = top.choose;
            c_dir = rdcg_pkg::DIR_REV;
          end
        end
      endcase
    end
  end

  assign child_ok = (c_n > c_k) && (c_k != '0);
  assign room = (level < LW'(MAX_ELEMENTS));
  assign push_eff = do_child && child_ok && room;
  assign pop_eff = do_pop || (replace && !child_ok);

  always_comb begin
    child.size = c_n;
    child.choose = c_k;
    child.dir = c_dir;
    child.phase = rdcg_pkg::PH_ENTER;
    child.idx = (c_dir == rdcg_pkg::DIR_FWD) ? '0 : c_n - FW'(1);
    parent = top;
    parent.phase = phase_next;
  end

  assign lvl_m1 = level - LW'(1);
  assign lvl_m2 = level - LW'(2);

  assign sts.empty = (level == '0);
  assign sts.yield = yld && (level != '0);
  assign sts.pop_read = pop_eff && (level > LW'(1));

  always_comb begin
    tot_ext = FW'(total_elements);
    max_c = FW'(MAX_ELEMENTS);
    r_n = (tot_ext > max_c) ? max_c : tot_ext;
    r_k = FW'(chosen_size);
    r_ok = (r_n > r_k) && (r_k != '0);
    r_frame.size = r_n;
    r_frame.choose = r_k;
    r_frame.dir = rdcg_pkg::DIR_FWD;
    r_frame.phase = rdcg_pkg::PH_ENTER;
    r_frame.idx = '0;
  end

  rdcg_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ELEMENTS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.commit && push_eff),
    .waddr (lvl_m1[AW-1:0]),
    .wdata (parent),
    .re    (cmd.commit && sts.pop_read),
    .raddr (lvl_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_elements <= rdcg_pkg::TOTAL_RESET;
      chosen_size <= rdcg_pkg::CHOSEN_RESET;
      level <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == rdcg_pkg::REG_TOTAL) begin
          total_elements <= cfg_data;
        end else begin
          chosen_size <= cfg_data;
        end
      end
      if (cmd.accept && restart) begin
        level <= r_ok ? LW'(1) : '0;
      end else if (cmd.commit) begin
        if (push_eff) begin
          level <= level + LW'(1);
        end else if (pop_eff) begin
          level <= lvl_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && restart) begin
      top <= r_frame;
    end else if (cmd.load_top) begin
      top <= frame_t'(ram_rdata);
    end else if (cmd.commit) begin
      if (push_eff || (replace && child_ok)) begin
        top <= child;
      end else begin
        top.phase <= phase_next;
        top.idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.yield) begin
        first_index <= pa[rdcg_pkg::OUT_IDX_W-1:0];
        second_index <= pb[rdcg_pkg::OUT_IDX_W-1:0];
        pair_valid <= 1'b1;
        finished <= 1'b0;
      end else begin
        first_index <= '0;
        second_index <= '0;
        pair_valid <= 1'b0;
        finished <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/revolving_door_combination_gray_top.sv
// after accept the control steps through frames until one yields a pair or the stack
//   is empty; a pop that reloads the top frame from the stack ram passes a load state
// one word in flight: no new request is taken until the last word is loaded for output
// the word rate is set by the frame stack walk, one frame step per cycle unless a stack
//   reload or a full output holds it; the ram has one write and one read port
// reset: control idle, stack empty, n=4 and k=2; stack ram is not cleared
module revolving_door_combination_gray_top #(
  parameter int MAX_ELEMENTS = rdcg_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rdcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdcg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rdcg_pkg::OUT_IDX_W-1:0] first_index,
  output logic [rdcg_pkg::OUT_IDX_W-1:0] second_index,
  output logic                           pair_valid,
  output logic                           finished
);

  rdcg_pkg::cmd_t cmd;
  rdcg_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rdcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdcg_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (restart),
    .cmd          (cmd),
    .sts          (sts),
    .first_index  (first_index),
    .second_index (second_index),
    .pair_valid   (pair_valid),
    .finished     (finished)
  );

endmodule

>>> verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N = rdcg_pkg::DEF_MAX_ELEMENTS;
  localparam int SETTLE = 2 * MAX_N + 8;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rdcg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rdcg_pkg::CFG_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic                           restart;
  logic                           out_valid;
  logic                           out_ready;
  logic [rdcg_pkg::OUT_IDX_W-1:0] first_index;
  logic [rdcg_pkg::OUT_IDX_W-1:0] second_index;
  logic                           pair_valid;
  logic                           finished;

  revolving_door_combination_gray_top #(
    .MAX_ELEMENTS(MAX_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_index(first_index),
    .second_index(second_index),
    .pair_valid(pair_valid),
    .finished(finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [5:0]                   size;
    logic [5:0]                   choose;
    logic                         dir;
    logic [rdcg_pkg::PHASE_W-1:0] phase;
    logic [5:0]                   pos;
  } door_frame_t;

  typedef struct packed {
    logic [rdcg_pkg::OUT_IDX_W-1:0] first;
    logic [rdcg_pkg::OUT_IDX_W-1:0] second;
    logic                           pair;
    logic                           done;
  } door_move_t;

  door_frame_t door_frames [MAX_N];
  int          door_depth;
  logic [5:0]  shadow_total;
  logic [5:0]  shadow_chosen;
  door_move_t  pending_moves[$];
  bit          last_done;
  bit          calm;
  int          hold_request;
  int          errors;
  int          swept;

  // frame stack predictor
  function automatic void push_door(int n, int k, logic dir);
    if (n <= k || k == 0) return;
    if (door_depth >= MAX_N) return;
    door_frames[door_depth].size   = 6'(n);
    door_frames[door_depth].choose = 6'(k);
    door_frames[door_depth].dir    = dir;
    door_frames[door_depth].phase  = rdcg_pkg::PH_ENTER;
    door_frames[door_depth].pos    = (dir == rdcg_pkg::DIR_FWD) ? 6'd0 : 6'(n - 1);
    door_depth++;
  endfunction

  function automatic bit next_swap(output int a, output int b);
    int   t;
    int   n;
    int   k;
    int   p;
    logic d;
    a = 0;
    b = 0;
    while (door_depth > 0) begin
      t = door_depth - 1;
      n = door_frames[t].size;
      k = door_frames[t].choose;
      d = door_frames[t].dir;
      p = door_frames[t].pos;
      if (k == 1) begin
        if (d == rdcg_pkg::DIR_FWD) begin
          if (p + 1 < n) begin
            a = p;
            b = p + 1;
            door_frames[t].pos = 6'(p + 1);
            return 1'b1;
          end
        end else if (p != 0) begin
          a = p;
          b = p - 1;
          door_frames[t].pos = 6'(p - 1);
          return 1'b1;
        end
        door_depth--;
        continue;
      end
      unique case (door_frames[t].phase)
        rdcg_pkg::PH_ENTER: begin
          door_frames[t].phase = rdcg_pkg::PH_PAIR_A;
          if (d == rdcg_pkg::DIR_FWD) push_door(n - 1, k, rdcg_pkg::DIR_FWD);
          else push_door(n - 2, k - 2, rdcg_pkg::DIR_REV);
        end
        rdcg_pkg::PH_PAIR_A: begin
          door_frames[t].phase = rdcg_pkg::PH_MID;
          a = n - 2;
          b = (d == rdcg_pkg::DIR_FWD) ? n - 1 : k - 2;
          return 1'b1;
        end
        rdcg_pkg::PH_MID: begin
          door_frames[t].phase = rdcg_pkg::PH_PAIR_B;
          push_door(n - 2, k - 1,
                    (d == rdcg_pkg::DIR_FWD) ? rdcg_pkg::DIR_REV : rdcg_pkg::DIR_FWD);
        end
        rdcg_pkg::PH_PAIR_B: begin
          door_frames[t].phase = rdcg_pkg::PH_TAIL;
          if (d == rdcg_pkg::DIR_FWD) begin
            a = k - 2;
            b = n - 2;
          end else begin
            a = n - 1;
            b = n - 2;
          end
          return 1'b1;
        end
        default: begin
          // last child takes the place of this frame
          door_depth--;
          if (d == rdcg_pkg::DIR_FWD) push_door(n - 2, k - 2, rdcg_pkg::DIR_FWD);
          else push_door(n - 1, k, rdcg_pkg::DIR_REV);
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic void predict_move(logic rs);
    int         n;
    int         a;
    int         b;
    bit         got;
    door_move_t m;
    if (rs) begin
      n = (int'(shadow_total) > MAX_N) ? MAX_N : int'(shadow_total);
      door_depth = 0;
      push_door(n, int'(shadow_chosen), rdcg_pkg::DIR_FWD);
    end
    got = next_swap(a, b);
    m.first  = got ? a[rdcg_pkg::OUT_IDX_W-1:0] : '0;
    m.second = got ? b[rdcg_pkg::OUT_IDX_W-1:0] : '0;
    m.pair   = got;
    m.done   = !got;
    pending_moves.push_back(m);
    last_done = !got;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_request(input logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    predict_move(rs);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] total, input logic [5:0] chosen);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= rdcg_pkg::REG_TOTAL;
    cfg_data  <= total;
    do @(posedge clk); while (!cfg_ready);
    shadow_total = total;
    cfg_index <= rdcg_pkg::REG_CHOSEN;
    cfg_data  <= chosen;
    do @(posedge clk); while (!cfg_ready);
    shadow_chosen = chosen;
    cfg_valid <= 1'b0;
  endtask

  // receiver side
  initial begin
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    door_move_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected word, actual %0d %0d pair %0d finished %0d", $time,
                 first_index, second_index, pair_valid, finished);
        errors++;
      end else begin
        want = pending_moves.pop_front();
        check_field("first_index", want.first, first_index);
        check_field("second_index", want.second, second_index);
        check_field("pair_valid", want.pair, pair_valid);
        check_field("finished", want.done, finished);
      end
    end
  end

  task automatic test_no_restart();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  task automatic test_reset_config();
    send_request(1'b1);
    repeat (6) send_request(1'b0);
  endtask

  task automatic test_empty_sequences();
    set_config(6'd5, 6'd0);
    send_request(1'b1);
    set_config(6'd3, 6'd3);
    send_request(1'b1);
    set_config(6'd5, 6'd63);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  task automatic test_saturation();
    set_config(6'd63, 6'd1);
    send_request(1'b1);
    send_request(1'b0);
    set_config(6'd40, 6'd31);
    send_request(1'b1);
    send_request(1'b0);
    set_config(6'd32, 6'd32);
    send_request(1'b1);
  endtask

  task automatic run_walk(input int cap);
    int count;
    int extra;
    send_request(1'b1);
    count = 1;
    extra = $urandom_range(0, 2);
    while (count < cap) begin
      if (last_done) begin
        if (extra == 0) break;
        extra--;
      end
      send_request($urandom_range(0, 99) < 3);
      count++;
    end
    swept += count;
  endtask

  task automatic test_long_sweeps();
    set_config(6'd32, 6'd1);
    run_walk(40);
    set_config(6'd48, 6'd31);
    run_walk(40);
    set_config(6'd32, 6'd2);
    run_walk(20);
  endtask

  task automatic test_backpressure();
    set_config(6'd6, 6'd3);
    hold_request = 300;
    send_request(1'b1);
    repeat (39) send_request(1'b0);
  endtask

  task automatic test_calm_stream();
    set_config(6'd8, 6'd4);
    calm = 1'b1;
    run_walk(80);
    calm = 1'b0;
  endtask

  task automatic test_random_walks();
    int r;
    int n;
    int k;
    while (swept < 1500) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if (r < 55) begin
          n = $urandom_range(1, 9);
          k = $urandom_range(0, n + 1);
        end else if (r < 62) begin
          n = $urandom_range(10, 16);
          k = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2) : n - $urandom_range(1, 2);
        end else if (r < 66) begin
          n = $urandom_range(32, 63);
          k = ($urandom_range(0, 1) == 0) ? 1 : 31;
        end else begin
          n = $urandom_range(0, 63);
          k = $urandom_range(0, 63);
        end
        set_config(6'(n), 6'(k));
      end
      run_walk(140);
    end
  endtask

  initial begin
    errors = 0;
    swept = 0;
    calm = 1'b0;
    hold_request = 0;
    last_done = 1'b1;
    door_depth = 0;
    shadow_total = rdcg_pkg::TOTAL_RESET;
    shadow_chosen = rdcg_pkg::CHOSEN_RESET;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= rdcg_pkg::REG_TOTAL;
    cfg_data <= '0;
    in_valid <= 1'b0;
    restart <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_restart();
    test_reset_config();
    test_empty_sequences();
    test_saturation();
    test_long_sweeps();
    test_backpressure();
    test_calm_stream();
    test_random_walks();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
